FILE: hw/rtl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types and constants for the decoder, the unit queue and the top level.
// ----------------------------------------------------------------------------
package u2u_pkg;

  // Field widths of one request and one result.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned AFTER_W = 2;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned CP_W    = 21;

  // Byte classification masks and patterns.
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  // Surrogate pair construction.
  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
  localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

  // Result queue sizing: two pushes per cycle need at least four slots.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Decode mode, one-hot.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_COLLECT = 3'b010,
    MODE_DISCARD = 3'b100
  } mode_t;

  // Units produced by one decoded byte.
  typedef struct packed {
    logic [1:0]        num;
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
  } dec_res_t;

  // One queued code unit.
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              last;
  } unit_ent_t;

endpackage

FILE: hw/rtl/u2u_if.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder channels
// Valid/ready channels for UTF-8 byte requests and UTF-16 code unit results.
// ----------------------------------------------------------------------------
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic [1:0] bytes_after;

  modport source (output valid, output in_byte, output bytes_after, input ready);
  modport sink   (input valid, input in_byte, input bytes_after, output ready);
endinterface

interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_last;

  modport source (output valid, output code_unit, output unit_last, input ready);
  modport sink   (input valid, input code_unit, input unit_last, output ready);
endinterface

FILE: hw/rtl/utf8_to_utf16_transcoder_core.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder core
// Decodes a UTF-8 byte stream into UTF-16 code units and surrogate pairs.
// ----------------------------------------------------------------------------
// The core takes one UTF-8 byte per cycle with the count of string bytes that
// follow it, and returns the UTF-16 code units each byte completes, with
// unit_last set on the final unit of that byte. A byte is registered at its
// request and decoded from the input register; once the queue has room, its
// units are written to the queue and appear on the result channel from its
// head. Units leave through a four-entry queue at one unit per cycle while
// the result channel is ready; a surrogate pair takes two result units, which
// the preceding continuation bytes cover, so a steady stream runs at one byte
// per cycle. Input stalls only when the queue has room for under two units.
module utf8_to_utf16_transcoder_core (
  input  logic       clk,
  input  logic       rst_n,
  u2u_in_if.sink     in_ch,
  u2u_out_if.source  out_ch
);
  import u2u_pkg::*;

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic [1:0]        in_after_r;
  logic              room;
  logic              step;
  dec_res_t          res;

  // The input register advances when it is empty or the queue can absorb a pair.
  assign step        = in_valid_r && room;
  assign in_ch.ready = !in_valid_r || room;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r  <= in_ch.in_byte;
      in_after_r <= in_ch.bytes_after;
    end
  end

  // Decode step.
  u2u_decoder u_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .byte_in  (in_byte_r),
    .after_in (in_after_r),
    .res      (res)
  );

  // Result queue.
  u2u_unit_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (step),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

FILE: hw/rtl/u2u_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Holds the decode state and turns one byte into zero, one or two code units.
// ----------------------------------------------------------------------------
module u2u_decoder (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              byte_in,
  input  logic [1:0]              after_in,
  output u2u_pkg::dec_res_t       res
);
  import u2u_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic [CP_W-1:0]   acc_r, acc_nxt;

  logic [CP_W-1:0]   cont_acc;
  logic [1:0]        pend_dec;
  logic [CP_W-1:0]   emit_cp;
  logic [CP_W-1:0]   supp;
  logic              do_emit;
  logic [1:0]        extra;
  logic [CP_W-1:0]   lead_cp;
  logic              lead_ok;

  // Continuation byte folded into the accumulator.
  assign cont_acc = {acc_r[CP_W-7:0], byte_in[5:0]};
  assign pend_dec = pend_r - 2'd1;

  // Lead byte classification.
  always_comb begin
    lead_ok = 1'b1;
    extra   = 2'd0;
    lead_cp = '0;
    if ((byte_in & LEAD2_MASK) == LEAD2_PAT) begin
      extra   = 2'd1;
      lead_cp = {{(CP_W-5){1'b0}}, byte_in[4:0]};
    end else if ((byte_in & LEAD3_MASK) == LEAD3_PAT) begin
      extra   = 2'd2;
      lead_cp = {{(CP_W-4){1'b0}}, byte_in[3:0]};
    end else if ((byte_in & LEAD4_MASK) == LEAD4_PAT) begin
      extra   = 2'd3;
      lead_cp = {{(CP_W-3){1'b0}}, byte_in[2:0]};
    end else begin
      lead_ok = 1'b0;
    end
  end

  // State update and result selection for one byte.
  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    do_emit   = 1'b0;
    res.num   = 2'd0;
    res.unit0 = {8'h00, byte_in};
    res.unit1 = '0;
    case (mode_r)
      MODE_DISCARD: begin
        if (after_in == 2'd0) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_COLLECT: begin
        if ((byte_in & CONT_MASK) != CONT_PAT) begin
          mode_nxt = MODE_IDLE;
          pend_nxt = 2'd0;
        end else begin
          acc_nxt  = cont_acc;
          pend_nxt = pend_dec;
          if (pend_dec == 2'd0) begin
            mode_nxt = MODE_IDLE;
            do_emit  = 1'b1;
          end else if (after_in == 2'd0) begin
            mode_nxt = MODE_IDLE;
            pend_nxt = 2'd0;
          end
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (!byte_in[7]) begin
          res.num = 2'd1;
        end else if (lead_ok) begin
          if (extra > after_in) begin
            if (after_in != 2'd0) begin
              mode_nxt = MODE_DISCARD;
            end
            pend_nxt = 2'd0;
          end else begin
            mode_nxt = MODE_COLLECT;
            pend_nxt = extra;
            acc_nxt  = lead_cp;
          end
        end
      end
    endcase

    // A finished code point: one unit, or a surrogate pair above the BMP.
    if (do_emit) begin
      if (emit_cp[CP_W-1:UNIT_W] == '0) begin
        res.num   = 2'd1;
        res.unit0 = emit_cp[UNIT_W-1:0];
      end else begin
        res.num   = 2'd2;
        res.unit0 = HI_SURR + {5'd0, supp[CP_W-1:10]};
        res.unit1 = LO_SURR | {6'd0, supp[9:0]};
      end
    end
  end

  assign emit_cp = cont_acc;
  assign supp    = emit_cp - SUPP_BASE;

  // Decode state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

FILE: hw/rtl/u2u_unit_queue.sv
// ----------------------------------------------------------------------------
// Code unit queue
// Small queue that takes up to two code units a cycle and hands out one.
// ----------------------------------------------------------------------------
module u2u_unit_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  u2u_pkg::dec_res_t       res,
  output logic                    room,
  u2u_out_if.source               out_ch
);
  import u2u_pkg::*;

  unit_ent_t           ent_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [QPTR_W-1:0]   wptr_p1;
  logic                pop;
  logic [1:0]          npush;

  // Room for a full pair regardless of this cycle's pop.
  assign room    = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign pop     = out_ch.valid && out_ch.ready;
  assign npush   = push ? res.num : 2'd0;
  assign wptr_p1 = wptr_r + QPTR_W'(1);

  assign wptr_nxt = wptr_r + QPTR_W'(npush);
  assign rptr_nxt = rptr_r + QPTR_W'(pop);
  assign cnt_nxt  = cnt_r + QCNT_W'(npush) - QCNT_W'(pop);

  // Head of the queue drives the result channel.
  assign out_ch.valid     = cnt_r != '0;
  assign out_ch.code_unit = ent_r[rptr_r].unit;
  assign out_ch.unit_last = ent_r[rptr_r].last;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      ent_r[wptr_r].unit <= res.unit0;
      ent_r[wptr_r].last <= (npush == 2'd1);
    end
    if (npush == 2'd2) begin
      ent_r[wptr_p1].unit <= res.unit1;
      ent_r[wptr_p1].last <= 1'b1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
